/* hw/rtl/microdegree_to_dms_rational_defines.svh */
// Assertion macros used by the checker file of the DMS converter.
// Depends on nothing; the user must have clk and rst_n in scope.
`ifndef MICRODEGREE_TO_DMS_RATIONAL_DEFINES_SVH
`define MICRODEGREE_TO_DMS_RATIONAL_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MDR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mdr_pkg.sv */
// Package of the DMS converter: field widths, constants, sequencer states
// and the denominator lookup. Depends on nothing.
package mdr_pkg;

    localparam int COORD_W   = 29;
    localparam int DEG_W     = 8;
    localparam int MIN_W     = 6;
    localparam int NUMER_W   = 26;
    localparam int DENOM_W   = 20;
    localparam int ACC_W     = 28;
    localparam int QUO_W     = 8;
    localparam int CNT_W     = 3;
    localparam int FACTOR_W  = 3;
    localparam int Q_W       = 24;
    localparam int RECIP_W   = 32;
    localparam int PROD_W    = NUMER_W + RECIP_W;

    localparam logic [ACC_W-1:0]   MICRO_PER_UNIT = ACC_W'(1000000);
    localparam logic [COORD_W-1:0] MAG_LIMIT      = COORD_W'(180000000);

    // Restoring division steps: 8 quotient bits for degrees, 6 for minutes.
    localparam logic [CNT_W-1:0] DEG_TOP = CNT_W'(DEG_W - 1);
    localparam logic [CNT_W-1:0] MIN_TOP = CNT_W'(MIN_W - 1);

    // One million is 2^6 * 5^6.
    localparam logic [FACTOR_W-1:0] FACTOR_MAX = FACTOR_W'(6);

    // floor(x / 5) == (x * RECIP5) >> RECIP5_SHIFT for any x below 2^32.
    localparam logic [RECIP_W-1:0] RECIP5       = 32'hCCCC_CCCD;
    localparam int                 RECIP5_SHIFT = 34;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEG,
        ST_SCALE_M,
        ST_MIN,
        ST_SCALE_S,
        ST_TWO,
        ST_FIVE_MUL,
        ST_FIVE_CHK
    } mdr_state_t;

    localparam logic [DENOM_W-1:0] POW5 [0:6] = '{
        DENOM_W'(1), DENOM_W'(5), DENOM_W'(25), DENOM_W'(125),
        DENOM_W'(625), DENOM_W'(3125), DENOM_W'(15625)
    };

    // Reduced denominator 2^(6-e2) * 5^(6-e5) once e2 twos and e5 fives are removed.
    function automatic logic [DENOM_W-1:0] denom_of(input logic [FACTOR_W-1:0] e2,
                                                    input logic [FACTOR_W-1:0] e5);
        logic [FACTOR_W-1:0] left2;
        logic [FACTOR_W-1:0] left5;
        begin
            left2 = FACTOR_MAX - e2;
            left5 = FACTOR_MAX - e5;
            return POW5[left5] << left2;
        end
    endfunction

endpackage

/* hw/rtl/mdr_in_if.sv */
// Input channel of the DMS converter: valid, ready and the coordinate.
// Depends on mdr_pkg.
interface mdr_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mdr_pkg::COORD_W-1:0]    coord_micro;

    modport source (output valid, output coord_micro, input ready);
    modport sink   (input valid, input coord_micro, output ready);
endinterface

/* hw/rtl/mdr_out_if.sv */
// Result channel of the DMS converter: valid, ready and the DMS fields.
// Depends on mdr_pkg.
interface mdr_out_if;
    logic                           valid;
    logic                           ready;
    logic [mdr_pkg::DEG_W-1:0]      deg_whole;
    logic [mdr_pkg::MIN_W-1:0]      min_whole;
    logic [mdr_pkg::NUMER_W-1:0]    sec_numer;
    logic [mdr_pkg::DENOM_W-1:0]    sec_denom;

    modport source (output valid, output deg_whole, output min_whole,
                    output sec_numer, output sec_denom, input ready);
    modport sink   (input valid, input deg_whole, input min_whole,
                    input sec_numer, input sec_denom, output ready);
endinterface

/* hw/rtl/microdegree_to_dms_rational.sv */
// Channel  Dir  Payload                                           Transfer when
// coord    in   coord_micro (29b signed, millionths of a degree)  valid && ready
// dms      out  deg_whole, min_whole, sec_numer, sec_denom         valid && ready
//
// One coordinate passes through the shared 28-bit compare-subtract unit (8 degree
// and 6 minute steps, with the minute and seconds scaling steps), then removes up
// to six factors of two and tries factors of five on the 26x32 multiplier. The input
// is ready only when idle, so a new coordinate is taken only after the last result
// is loaded. A stalled sink holds the result register, and a later result waits in
// the last step. rst_n (asynchronous, low) empties the block.
//
// Top level of the DMS converter. Depends on mdr_pkg, mdr_in_if, mdr_out_if.
module microdegree_to_dms_rational (
    input  logic          clk,
    input  logic          rst_n,
    mdr_in_if.sink        coord,
    mdr_out_if.source     dms
);

    mdr_pkg::mdr_state_t state_reg, state_next;

    // The accumulator holds the magnitude, then each remainder, and finally
    // the seconds numerator while it is being reduced.
    logic [mdr_pkg::ACC_W-1:0]    acc_reg,  acc_next;
    logic [mdr_pkg::QUO_W-1:0]    quo_reg,  quo_next;
    logic [mdr_pkg::CNT_W-1:0]    cnt_reg,  cnt_next;
    logic [mdr_pkg::DEG_W-1:0]    deg_reg,  deg_next;
    logic [mdr_pkg::MIN_W-1:0]    min_reg,  min_next;
    logic [mdr_pkg::FACTOR_W-1:0] e2_reg,   e2_next;
    logic [mdr_pkg::FACTOR_W-1:0] e5_reg,   e5_next;
    logic [mdr_pkg::Q_W-1:0]      q_reg,    q_next;

    logic                          out_valid_reg, out_valid_next;
    logic [mdr_pkg::DEG_W-1:0]     out_deg_reg,   out_deg_next;
    logic [mdr_pkg::MIN_W-1:0]     out_min_reg,   out_min_next;
    logic [mdr_pkg::NUMER_W-1:0]   out_num_reg,   out_num_next;
    logic [mdr_pkg::DENOM_W-1:0]   out_den_reg,   out_den_next;

    logic                          in_xfer;
    logic                          out_xfer;
    logic                          out_free;
    logic                          step_last;
    logic                          five_match;
    logic                          result_load;

    // Saturated magnitude of the incoming coordinate.
    logic [mdr_pkg::COORD_W-1:0]   coord_raw;
    logic [mdr_pkg::COORD_W-1:0]   coord_mag;
    logic [mdr_pkg::COORD_W-1:0]   coord_sat;

    // Shared compare-subtract unit with its shifted divisor.
    logic [mdr_pkg::ACC_W-1:0]     divisor;
    logic [mdr_pkg::ACC_W:0]       diff;
    logic                          ge;
    logic [mdr_pkg::QUO_W-1:0]     quo_shift;

    // Times sixty as 64x - 4x; the operand is always below one million.
    logic [mdr_pkg::ACC_W-1:0]     acc_x60;

    // Reciprocal multiply for the factor-of-five test.
    logic [mdr_pkg::PROD_W-1:0]    prod;
    logic [mdr_pkg::NUMER_W-1:0]   q_times5;

    assign in_xfer  = coord.valid && coord.ready;
    assign out_xfer = dms.valid && dms.ready;
    assign out_free = !out_valid_reg || dms.ready;

    assign coord_raw = $unsigned(coord.coord_micro);
    assign coord_mag = coord_raw[mdr_pkg::COORD_W-1] ? ({mdr_pkg::COORD_W{1'b0}} - coord_raw)
                                                       : coord_raw;
    assign coord_sat = (coord_mag > mdr_pkg::MAG_LIMIT) ? mdr_pkg::MAG_LIMIT : coord_mag;

    assign divisor   = mdr_pkg::MICRO_PER_UNIT << cnt_reg;
    assign diff      = {1'b0, acc_reg} - {1'b0, divisor};
    assign ge        = !diff[mdr_pkg::ACC_W];
    assign quo_shift = {quo_reg[mdr_pkg::QUO_W-2:0], ge};
    assign step_last = (cnt_reg == '0);

    assign acc_x60 = (acc_reg << 6) - (acc_reg << 2);

    assign prod       = mdr_pkg::PROD_W'(acc_reg[mdr_pkg::NUMER_W-1:0])
                      * mdr_pkg::PROD_W'(mdr_pkg::RECIP5);
    assign q_times5   = {q_reg, 2'b00} + mdr_pkg::NUMER_W'(q_reg);
    assign five_match = (q_times5 == acc_reg[mdr_pkg::NUMER_W-1:0]);

    // The reduction is finished when the five test fails or all six fives are out.
    assign result_load = (state_reg == mdr_pkg::ST_FIVE_CHK) && out_free &&
                         (!five_match || (e5_reg == mdr_pkg::FACTOR_MAX));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mdr_pkg::ST_IDLE:
            begin
                if (in_xfer)
                    state_next = mdr_pkg::ST_DEG;
            end
            mdr_pkg::ST_DEG:
            begin
                if (step_last)
                    state_next = mdr_pkg::ST_SCALE_M;
            end
            mdr_pkg::ST_SCALE_M:
                state_next = mdr_pkg::ST_MIN;
            mdr_pkg::ST_MIN:
            begin
                if (step_last)
                    state_next = mdr_pkg::ST_SCALE_S;
            end
            mdr_pkg::ST_SCALE_S:
                state_next = mdr_pkg::ST_TWO;
            mdr_pkg::ST_TWO:
            begin
                if (acc_reg[0] || (e2_reg == mdr_pkg::FACTOR_MAX))
                    state_next = mdr_pkg::ST_FIVE_MUL;
            end
            mdr_pkg::ST_FIVE_MUL:
                state_next = mdr_pkg::ST_FIVE_CHK;
            mdr_pkg::ST_FIVE_CHK:
            begin
                priority if (result_load)
                    state_next = mdr_pkg::ST_IDLE;
                else if (five_match && (e5_reg != mdr_pkg::FACTOR_MAX))
                    state_next = mdr_pkg::ST_FIVE_MUL;
            end
            default:
                state_next = mdr_pkg::ST_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        acc_next = acc_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        deg_next = deg_reg;
        min_next = min_reg;
        e2_next  = e2_reg;
        e5_next  = e5_reg;
        q_next   = q_reg;
        unique case (state_reg)
            mdr_pkg::ST_IDLE:
            begin
                acc_next = mdr_pkg::ACC_W'(coord_sat);
                quo_next = '0;
                cnt_next = mdr_pkg::DEG_TOP;
            end
            mdr_pkg::ST_DEG, mdr_pkg::ST_MIN:
            begin
                if (ge)
                    acc_next = diff[mdr_pkg::ACC_W-1:0];
                quo_next = quo_shift;
                cnt_next = cnt_reg - 1'b1;
                if (step_last && (state_reg == mdr_pkg::ST_DEG))
                    deg_next = quo_shift;
                if (step_last && (state_reg == mdr_pkg::ST_MIN))
                    min_next = quo_shift[mdr_pkg::MIN_W-1:0];
            end
            mdr_pkg::ST_SCALE_M:
            begin
                acc_next = acc_x60;
                quo_next = '0;
                cnt_next = mdr_pkg::MIN_TOP;
            end
            mdr_pkg::ST_SCALE_S:
            begin
                acc_next = acc_x60;
                e2_next  = '0;
                e5_next  = '0;
            end
            mdr_pkg::ST_TWO:
            begin
                if (!acc_reg[0] && (e2_reg != mdr_pkg::FACTOR_MAX))
                begin
                    acc_next = acc_reg >> 1;
                    e2_next  = e2_reg + 1'b1;
                end
            end
            mdr_pkg::ST_FIVE_MUL:
                q_next = prod[mdr_pkg::RECIP5_SHIFT +: mdr_pkg::Q_W];
            mdr_pkg::ST_FIVE_CHK:
            begin
                // A zero numerator passes every test, leaving 0 over 1.
                if (five_match && (e5_reg != mdr_pkg::FACTOR_MAX))
                begin
                    acc_next = mdr_pkg::ACC_W'(q_reg);
                    e5_next  = e5_reg + 1'b1;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Output register and handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_deg_next   = out_deg_reg;
        out_min_next   = out_min_reg;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        if (result_load)
        begin
            out_valid_next = 1'b1;
            out_deg_next   = deg_reg;
            out_min_next   = min_reg;
            out_num_next   = acc_reg[mdr_pkg::NUMER_W-1:0];
            out_den_next   = mdr_pkg::denom_of(e2_reg, e5_reg);
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign coord.ready   = (state_reg == mdr_pkg::ST_IDLE);
    assign dms.valid     = out_valid_reg;
    assign dms.deg_whole = out_deg_reg;
    assign dms.min_whole = out_min_reg;
    assign dms.sec_numer = out_num_reg;
    assign dms.sec_denom = out_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mdr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        deg_reg     <= deg_next;
        min_reg     <= min_next;
        e2_reg      <= e2_next;
        e5_reg      <= e5_next;
        q_reg       <= q_next;
        out_deg_reg <= out_deg_next;
        out_min_reg <= out_min_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
    end

endmodule

/* hw/rtl/mdr_checker.sv */
// Port-level checks of the DMS converter and the bind that attaches them.
// Depends on mdr_pkg and microdegree_to_dms_rational_defines.svh.
`include "microdegree_to_dms_rational_defines.svh"

module mdr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [mdr_pkg::DEG_W-1:0]      deg_whole,
    input logic [mdr_pkg::MIN_W-1:0]      min_whole,
    input logic [mdr_pkg::NUMER_W-1:0]    sec_numer,
    input logic [mdr_pkg::DENOM_W-1:0]    sec_denom
);

    `MDR_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready,
        "input still ready after a coordinate transfer")

    `MDR_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid),
        "result appeared right after a coordinate transfer")

    `MDR_ASSERT_NOW(a_result_range, out_valid,
        (deg_whole <= 8'd180) && (min_whole <= 6'd59) && (sec_denom != '0) &&
        (sec_numer <= 26'd59999940),
        "result field out of range")

    `MDR_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
        out_valid && $stable(deg_whole) && $stable(min_whole) &&
        $stable(sec_numer) && $stable(sec_denom),
        "stalled result changed")

endmodule

bind microdegree_to_dms_rational mdr_checker u_mdr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (coord.valid),
    .in_ready  (coord.ready),
    .out_valid (dms.valid),
    .out_ready (dms.ready),
    .deg_whole (dms.deg_whole),
    .min_whole (dms.min_whole),
    .sec_numer (dms.sec_numer),
    .sec_denom (dms.sec_denom)
);
